[design/ets_pkg.sv]
// Shared types, constants and the CORDIC angle table for the ellipse setpoint block.
package ets_pkg;

  localparam int CORDIC_STAGES = 24;
  // at most 32 iterations are meaningful for a 32-bit binary angle
  localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int CW = 34;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // 1/K in Q4.30
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_AXIS_X   = 2'd2,
    REG_AXIS_Y   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [31:0] angle;
    logic signed [31:0] angle_rate;
    logic signed [31:0] angle_accel;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic               saturated;
  } out_word_t;

  // angle folded to [-90, 90) degrees plus the half-turn flag
  typedef struct packed {
    logic               flip;
    logic signed [CW-1:0] z;
    logic signed [31:0] rate;
    logic signed [31:0] accel;
  } cls_word_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
  } cfg_regs_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic signed [CW-1:0] atan_val(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      5'd31: v = 30'd0;
      default: v = 30'd0;
    endcase
    return $signed({{(CW-30){1'b0}}, v});
  endfunction

endpackage

[design/ets_front.sv]
// Input stage: takes a word and folds the angle into the CORDIC range.
module ets_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ets_pkg::in_word_t    in_data,
  output logic                 cls_valid,
  input  logic                 cls_ready,
  output ets_pkg::cls_word_t   cls_data
);

  logic               valid_r, valid_nxt;
  ets_pkg::cls_word_t word_r, word_nxt;
  logic               flip;
  logic [31:0]        folded;
  logic               take;

  // second and third quadrant: subtract half a turn, negate cos and sin later
  always_comb begin
    flip   = in_data.angle[31] ^ in_data.angle[30];
    folded = {in_data.angle[31] ^ flip, in_data.angle[30:0]};
    word_nxt.flip  = flip;
    word_nxt.z     = $signed({{(ets_pkg::CW-32){folded[31]}}, folded});
    word_nxt.rate  = in_data.angle_rate;
    word_nxt.accel = in_data.angle_accel;
  end

  assign in_ready  = !valid_r || cls_ready;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take || (valid_r && !cls_ready);
  assign cls_valid = valid_r;
  assign cls_data  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end

endmodule

[design/ets_queue.sv]
// Small FIFO between the input stage and the compute pipeline.
module ets_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  output logic                      push_ready,
  input  ets_pkg::cls_word_t        push_data,
  output logic                      pop_valid,
  input  logic                      pop_ready,
  output ets_pkg::cls_word_t        pop_data,
  output logic [ets_pkg::QAW:0]     level
);

  localparam logic [ets_pkg::QAW:0] FULL = (ets_pkg::QAW+1)'(ets_pkg::QDEPTH);
  localparam logic [ets_pkg::QAW-1:0] LAST = ets_pkg::QAW'(ets_pkg::QDEPTH - 1);

  ets_pkg::cls_word_t        mem_r [ets_pkg::QDEPTH];
  logic [ets_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ets_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ets_pkg::QAW:0]     count_r, count_nxt;
  logic                      push, pop;

  assign push_ready = count_r != FULL;
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];
  assign level      = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + (ets_pkg::QAW+1)'(push) - (ets_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/ets_cordic.sv]
// Pipelined rotation-mode CORDIC, one iteration per stage, plus the half-turn fix-up.
module ets_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  ets_pkg::cls_word_t  in_data,
  output logic                out_valid,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o,
  output logic signed [31:0]  rate_o,
  output logic signed [31:0]  accel_o
);

  localparam int N  = ets_pkg::NSTG;
  localparam int CW = ets_pkg::CW;

  logic signed [CW-1:0] x_r [N];
  logic signed [CW-1:0] y_r [N];
  logic signed [CW-1:0] z_r [N];
  logic                 flip_r [N];
  logic signed [31:0]   rate_r [N];
  logic signed [31:0]   accel_r [N];
  logic                 vld_r [N];

  logic signed [CW-1:0] x_in [N];
  logic signed [CW-1:0] y_in [N];
  logic signed [CW-1:0] z_in [N];
  logic signed [CW-1:0] x_nxt [N];
  logic signed [CW-1:0] y_nxt [N];
  logic signed [CW-1:0] z_nxt [N];

  logic signed [CW-1:0] xf, yf;
  logic signed [31:0]   cos_r, sin_r, rate_out_r, accel_out_r;
  logic                 out_valid_r;

  always_comb begin
    x_in[0] = ets_pkg::CORDIC_X0;
    y_in[0] = '0;
    z_in[0] = in_data.z;
    for (int k = 1; k < N; k++) begin
      x_in[k] = x_r[k-1];
      y_in[k] = y_r[k-1];
      z_in[k] = z_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      if (!z_in[k][CW-1]) begin
        x_nxt[k] = x_in[k] - (y_in[k] >>> k);
        y_nxt[k] = y_in[k] + (x_in[k] >>> k);
        z_nxt[k] = z_in[k] - ets_pkg::atan_val(5'(k));
      end else begin
        x_nxt[k] = x_in[k] + (y_in[k] >>> k);
        y_nxt[k] = y_in[k] - (x_in[k] >>> k);
        z_nxt[k] = z_in[k] + ets_pkg::atan_val(5'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      z_r       <= z_nxt;
      flip_r[0]  <= in_data.flip;
      rate_r[0]  <= in_data.rate;
      accel_r[0] <= in_data.accel;
      for (int k = 1; k < N; k++) begin
        flip_r[k]  <= flip_r[k-1];
        rate_r[k]  <= rate_r[k-1];
        accel_r[k] <= accel_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[N-1];
    end
  end

  assign xf = flip_r[N-1] ? -x_r[N-1] : x_r[N-1];
  assign yf = flip_r[N-1] ? -y_r[N-1] : y_r[N-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r       <= $signed(xf[31:0]);
      sin_r       <= $signed(yf[31:0]);
      rate_out_r  <= rate_r[N-1];
      accel_out_r <= accel_r[N-1];
    end
  end

  assign out_valid = out_valid_r;
  assign cos_o     = cos_r;
  assign sin_o     = sin_r;
  assign rate_o    = rate_out_r;
  assign accel_o   = accel_out_r;

endmodule

[design/ets_back.sv]
// Product, rounding, summing and saturation pipeline with the output register.
module ets_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ets_pkg::cfg_regs_t  cfg,
  input  logic                in_valid,
  input  logic signed [31:0]  cos_i,
  input  logic signed [31:0]  sin_i,
  input  logic signed [31:0]  rate_i,
  input  logic signed [31:0]  accel_i,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output ets_pkg::out_word_t  out_data
);

  // magnitude rounded half away from zero: (p + half - neg) >>> shift
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    t = t - $signed({63'd0, p[63]});
    return 34'(t >>> 30);
  endfunction

  function automatic logic signed [65:0] rnd16(input logic signed [81:0] p);
    logic signed [81:0] t;
    t = p + 82'sd32768;
    t = t - $signed({81'd0, p[81]});
    return 66'(t >>> 16);
  endfunction

  function automatic logic [32:0] sat32(input logic signed [66:0] v);
    logic [32:0] r;
    if (v > 67'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -67'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  // stage 1: axis times trig, rate squared
  logic signed [63:0] ac1_r, as1_r, bc1_r, bs1_r, ww1_r;
  logic signed [31:0] rate1_r, accel1_r;
  // stage 2: rounded Q16.16 terms
  logic signed [33:0] ac2_r, as2_r, bc2_r, bs2_r;
  logic signed [47:0] ww2_r;
  logic signed [31:0] rate2_r, accel2_r;
  // stage 3: second-level partial products, positions
  logic signed [65:0] vx3_r, vy3_r, xa3_r, ya3_r;
  logic signed [58:0] xwl3_r, ywl3_r;
  logic signed [57:0] xwh3_r, ywh3_r;
  logic signed [34:0] px3_r, py3_r;
  // stage 4
  logic signed [81:0] xw4_r, yw4_r;
  logic signed [49:0] vx4_r, vy4_r, xa4_r, ya4_r;
  logic signed [34:0] px4_r, py4_r;
  // stage 5
  logic signed [65:0] xw5_r, yw5_r;
  logic signed [49:0] vx5_r, vy5_r, xa5_r, ya5_r;
  logic signed [34:0] px5_r, py5_r;

  ets_pkg::out_word_t out_r, out_nxt;
  logic [32:0] s_px, s_py, s_vx, s_vy, s_ax, s_ay;

  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ac1_r    <= $signed(cfg.axis_x) * cos_i;
      as1_r    <= $signed(cfg.axis_x) * sin_i;
      bc1_r    <= $signed(cfg.axis_y) * cos_i;
      bs1_r    <= $signed(cfg.axis_y) * sin_i;
      ww1_r    <= rate_i * rate_i;
      rate1_r  <= rate_i;
      accel1_r <= accel_i;

      ac2_r    <= rnd30(ac1_r);
      as2_r    <= rnd30(as1_r);
      bc2_r    <= rnd30(bc1_r);
      bs2_r    <= rnd30(bs1_r);
      ww2_r    <= 48'(rnd16(82'(ww1_r)));
      rate2_r  <= rate1_r;
      accel2_r <= accel1_r;

      // rate squared reaches 47 bits: split it into two partial products
      vx3_r  <= as2_r * rate2_r;
      vy3_r  <= bc2_r * rate2_r;
      xa3_r  <= as2_r * accel2_r;
      ya3_r  <= bc2_r * accel2_r;
      xwl3_r <= ac2_r * $signed({1'b0, ww2_r[23:0]});
      xwh3_r <= ac2_r * $signed(ww2_r[47:24]);
      ywl3_r <= bs2_r * $signed({1'b0, ww2_r[23:0]});
      ywh3_r <= bs2_r * $signed(ww2_r[47:24]);
      px3_r  <= ac2_r + $signed(cfg.center_x);
      py3_r  <= bs2_r + $signed(cfg.center_y);

      xw4_r <= (82'(xwh3_r) <<< 24) + 82'(xwl3_r);
      yw4_r <= (82'(ywh3_r) <<< 24) + 82'(ywl3_r);
      vx4_r <= 50'(rnd16(82'(vx3_r)));
      vy4_r <= 50'(rnd16(82'(vy3_r)));
      xa4_r <= 50'(rnd16(82'(xa3_r)));
      ya4_r <= 50'(rnd16(82'(ya3_r)));
      px4_r <= px3_r;
      py4_r <= py3_r;

      xw5_r <= rnd16(xw4_r);
      yw5_r <= rnd16(yw4_r);
      vx5_r <= vx4_r;
      vy5_r <= vy4_r;
      xa5_r <= xa4_r;
      ya5_r <= ya4_r;
      px5_r <= px4_r;
      py5_r <= py4_r;

      out_r <= out_nxt;
    end
  end

  always_comb begin
    s_px = sat32(67'(px5_r));
    s_py = sat32(67'(py5_r));
    s_vx = sat32(-67'(vx5_r));
    s_vy = sat32(67'(vy5_r));
    s_ax = sat32(-67'(xw5_r) - 67'(xa5_r));
    s_ay = sat32(-67'(yw5_r) + 67'(ya5_r));
    out_nxt.pos_x     = $signed(s_px[31:0]);
    out_nxt.pos_y     = $signed(s_py[31:0]);
    out_nxt.vel_x     = $signed(s_vx[31:0]);
    out_nxt.vel_y     = $signed(s_vy[31:0]);
    out_nxt.acc_x     = $signed(s_ax[31:0]);
    out_nxt.acc_y     = $signed(s_ay[31:0]);
    out_nxt.saturated = s_px[32] | s_py[32] | s_vx[32] | s_vy[32] | s_ax[32] | s_ay[32];
  end

endmodule

[design/ellipse_trajectory_setpoint.sv]
// Ellipse setpoint generator top level: register port, input stage, FIFO, CORDIC, back end.
// Each input word (binary angle, rate, acceleration) yields one output word with the
// position, velocity and acceleration on the ellipse set by center_x/y and axis_x/y
// (registers at byte addresses 0, 4, 8, 12). One word is taken per cycle while the output
// is not stalled; the CORDIC runs one iteration per stage and the products run through
// the back-end pipeline to the output register. A stall on the output freezes the CORDIC
// and product pipeline; the 4-word FIFO and the input stage keep taking words until they
// fill. Write the registers only while no word is in flight; saturated flags any of the
// six values clipped to 32 bits.
module ellipse_trajectory_setpoint (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ets_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ets_pkg::out_word_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  ets_pkg::cfg_regs_t cfg_r, cfg_nxt;
  ets_pkg::cfg_reg_t  reg_sel;
  logic               cfg_wr;

  logic               cls_valid, cls_ready;
  ets_pkg::cls_word_t cls_data;
  logic               q_valid, q_pop, adv;
  ets_pkg::cls_word_t q_data;
  logic [ets_pkg::QAW:0] q_level;

  logic               trig_valid;
  logic signed [31:0] trig_cos, trig_sin, trig_rate, trig_accel;

  assign reg_sel    = ets_pkg::cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        ets_pkg::REG_CENTER_X: cfg_nxt.center_x = $signed(cfg_pwdata);
        ets_pkg::REG_CENTER_Y: cfg_nxt.center_y = $signed(cfg_pwdata);
        ets_pkg::REG_AXIS_X:   cfg_nxt.axis_x   = $signed(cfg_pwdata);
        ets_pkg::REG_AXIS_Y:   cfg_nxt.axis_y   = $signed(cfg_pwdata);
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ets_pkg::REG_CENTER_X: cfg_prdata = cfg_r.center_x;
      ets_pkg::REG_CENTER_Y: cfg_prdata = cfg_r.center_y;
      ets_pkg::REG_AXIS_X:   cfg_prdata = cfg_r.axis_x;
      ets_pkg::REG_AXIS_Y:   cfg_prdata = cfg_r.axis_y;
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ets_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data)
  );

  ets_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cls_valid),
    .push_ready (cls_ready),
    .push_data  (cls_data),
    .pop_valid  (q_valid),
    .pop_ready  (adv),
    .pop_data   (q_data),
    .level      (q_level)
  );

  assign q_pop = q_valid && adv;

  ets_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_data   (q_data),
    .out_valid (trig_valid),
    .cos_o     (trig_cos),
    .sin_o     (trig_sin),
    .rate_o    (trig_rate),
    .accel_o   (trig_accel)
  );

  ets_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (trig_valid),
    .cos_i     (trig_cos),
    .sin_i     (trig_sin),
    .rate_i    (trig_rate),
    .accel_i   (trig_accel),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a blocked output word must hold the whole pipeline, FIFO included
  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("FIFO popped while output word stalled");

  // FIFO never takes a word when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level == (ets_pkg::QAW+1)'(ets_pkg::QDEPTH)) |-> !(cls_valid && cls_ready))
    else $error("FIFO push while full");

  // FIFO level rises by one on a push without a pop
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cls_valid && cls_ready && !q_pop) |=> (q_level == $past(q_level) + 1'b1))
    else $error("FIFO level lost a word");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid after reset");

endmodule

[tb/ellipse_trajectory_setpoint_tb.sv]
// Self-checking testbench for the ellipse setpoint generator: reset, directed, saturation, stall, random.
`timescale 1ns / 100ps

module ellipse_trajectory_setpoint_tb;

  localparam int LATENCY = ets_pkg::CORDIC_STAGES + 8;
  localparam int ROT_STEPS = (ets_pkg::CORDIC_STAGES > 32) ? 32 : ets_pkg::CORDIC_STAGES;
  localparam longint GAIN_INV_Q30 = 652032874;
  localparam int TRIG_SHIFT = 30;
  localparam int Q_SHIFT = 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam int RANDOM_PHASES = 10;
  localparam int WORDS_PER_PHASE = 130;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ets_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ets_pkg::out_word_t out_data;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [3:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  ets_pkg::cfg_regs_t cfg_shadow;
  ets_pkg::out_word_t pending_setpoints[$];
  ets_pkg::out_word_t want_word;
  int                 mismatches = 0;
  bit                 tx_gaps_on = 1'b1;
  bit                 rx_stalls_on = 1'b1;
  int                 rx_hold_left = 0;
  int                 rx_stall_left = 0;

  ellipse_trajectory_setpoint u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // ---------------- predictor ----------------

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic longint atan_turn(input int i);
    case (i)
      0: return 536870912;   1: return 316933406;   2: return 167458907;
      3: return 85004756;    4: return 42667331;    5: return 21354465;
      6: return 10679838;    7: return 5340245;     8: return 2670163;
      9: return 1335087;     10: return 667544;     11: return 333772;
      12: return 166886;     13: return 83443;      14: return 41722;
      15: return 20861;      16: return 10430;      17: return 5215;
      18: return 2608;       19: return 1304;       20: return 652;
      21: return 326;        22: return 163;        23: return 81;
      24: return 41;         25: return 20;         26: return 10;
      27: return 5;          28: return 3;          29: return 1;
      30: return 1;          default: return 0;
    endcase
  endfunction

  function automatic void rotate_angle(input logic [31:0] ang, output longint cos_q30,
                                       output longint sin_q30);
    logic [31:0] folded;
    bit          flip;
    longint      x, y, z, nx;
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    folded = flip ? ang - 32'h8000_0000 : ang;
    z = longint'($signed(folded));
    x = GAIN_INV_Q30;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_turn(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_turn(i);
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // exact product scaled down, magnitude rounded half away from zero, capped past 2^63
  function automatic longint mul_round(input longint p, input longint q, input int sh);
    logic [63:0]  mp, mq, m;
    logic [127:0] prod, rounded;
    bit           neg;
    neg = (p < 0) != (q < 0);
    mp = (p < 0) ? -p : p;
    mq = (q < 0) ? -q : q;
    prod = {64'd0, mp} * {64'd0, mq};
    if (prod > (128'd1 << 63)) begin
      m = 64'h8000_0000_0000_0000 >> sh;
    end else begin
      rounded = (prod + (128'd1 << (sh - 1))) >> sh;
      m = rounded[63:0];
    end
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic ets_pkg::out_word_t ellipse_point(input ets_pkg::in_word_t w);
    longint             c, s, rate, accel, ax, ay;
    longint             ax_cos, ax_sin, ay_cos, ay_sin, rate_sq;
    longint             px, py, vx, vy, accx, accy;
    bit                 hit;
    ets_pkg::out_word_t r;
    hit = 1'b0;
    rotate_angle(w.angle, c, s);
    rate  = longint'(w.angle_rate);
    accel = longint'(w.angle_accel);
    ax = longint'(cfg_shadow.axis_x);
    ay = longint'(cfg_shadow.axis_y);
    ax_cos  = mul_round(ax, c, TRIG_SHIFT);
    ax_sin  = mul_round(ax, s, TRIG_SHIFT);
    ay_cos  = mul_round(ay, c, TRIG_SHIFT);
    ay_sin  = mul_round(ay, s, TRIG_SHIFT);
    rate_sq = mul_round(rate, rate, Q_SHIFT);
    px   = ax_cos + longint'(cfg_shadow.center_x);
    py   = ay_sin + longint'(cfg_shadow.center_y);
    vx   = -mul_round(ax_sin, rate, Q_SHIFT);
    vy   = mul_round(ay_cos, rate, Q_SHIFT);
    accx = -mul_round(ax_cos, rate_sq, Q_SHIFT) - mul_round(ax_sin, accel, Q_SHIFT);
    accy = -mul_round(ay_sin, rate_sq, Q_SHIFT) + mul_round(ay_cos, accel, Q_SHIFT);
    r.pos_x = clip32(px, hit);
    r.pos_y = clip32(py, hit);
    r.vel_x = clip32(vx, hit);
    r.vel_y = clip32(vy, hit);
    r.acc_x = clip32(accx, hit);
    r.acc_y = clip32(accy, hit);
    r.saturated = hit;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_tx_gap();
    if (!tx_gaps_on || $urandom_range(0, 9) < 6) return 0;
    return gap_len();
  endfunction

  function automatic ets_pkg::in_word_t mk_word(input logic [31:0] ang,
                                                input logic [31:0] rate,
                                                input logic [31:0] accel);
    ets_pkg::in_word_t w;
    w.angle = ang;
    w.angle_rate = rate;
    w.angle_accel = accel;
    return w;
  endfunction

  function automatic logic signed [31:0] rand_q16();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1, 2: begin
        v = $urandom_range(0, 32'h001F_FFFF);
        v = v - 32'sh0010_0000;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh0000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sh8000_0000;
          3: v = 32'sh0001_0000;
          default: v = -32'sh0001_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_reg_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        v = $urandom_range(0, 32'h007F_FFFF);
        v = v - 32'sh0040_0000;
      end
      6, 7: v = $urandom();
      default: begin
        case ($urandom_range(0, 2))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          default: v = 32'sh0000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic ets_pkg::in_word_t rand_word();
    ets_pkg::in_word_t w;
    logic [1:0]        quad;
    w.angle = $urandom();
    if ($urandom_range(0, 7) == 0) begin
      // land on or near a quadrant boundary
      quad = $urandom_range(0, 3);
      w.angle = {quad, 30'd0};
      w.angle = w.angle + $urandom_range(0, 8) - 4;
    end
    w.angle_rate = rand_q16();
    w.angle_accel = rand_q16();
    return w;
  endfunction

  task automatic send_word(input ets_pkg::in_word_t w);
    int gap;
    gap = pick_tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_setpoints.push_back(ellipse_point(w));
  endtask

  task automatic wait_results_done();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_setpoints.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input ets_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      ets_pkg::REG_CENTER_X: cfg_shadow.center_x = val;
      ets_pkg::REG_CENTER_Y: cfg_shadow.center_y = val;
      ets_pkg::REG_AXIS_X:   cfg_shadow.axis_x = val;
      ets_pkg::REG_AXIS_Y:   cfg_shadow.axis_y = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ellipse(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] ax, input logic [31:0] ay);
    write_reg(ets_pkg::REG_CENTER_X, cx);
    write_reg(ets_pkg::REG_CENTER_Y, cy);
    write_reg(ets_pkg::REG_AXIS_X, ax);
    write_reg(ets_pkg::REG_AXIS_Y, ay);
  endtask

  // ---------------- checking ----------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_setpoints.size() == 0) begin
        report_mismatch("word with none expected", out_data.pos_x, 32'd0);
      end else begin
        want_word = pending_setpoints.pop_front();
        if (out_data.pos_x !== want_word.pos_x)
          report_mismatch("pos_x", out_data.pos_x, want_word.pos_x);
        if (out_data.pos_y !== want_word.pos_y)
          report_mismatch("pos_y", out_data.pos_y, want_word.pos_y);
        if (out_data.vel_x !== want_word.vel_x)
          report_mismatch("vel_x", out_data.vel_x, want_word.vel_x);
        if (out_data.vel_y !== want_word.vel_y)
          report_mismatch("vel_y", out_data.vel_y, want_word.vel_y);
        if (out_data.acc_x !== want_word.acc_x)
          report_mismatch("acc_x", out_data.acc_x, want_word.acc_x);
        if (out_data.acc_y !== want_word.acc_y)
          report_mismatch("acc_y", out_data.acc_y, want_word.acc_y);
        if (out_data.saturated !== want_word.saturated)
          report_mismatch("saturated", out_data.saturated, want_word.saturated);
      end
    end
  end

  // output side: random stalls plus an on-demand long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        rx_stall_left = gap_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_reset_values();
    cfg_shadow = '0;
    repeat (3) send_word(rand_word());
    wait_results_done();
  endtask

  task automatic test_directed_extremes();
    // centre (1.5, -2.25), axes 10.0 and -5.0
    set_ellipse(32'h0001_8000, 32'hFFFD_C000, 32'h000A_0000, 32'hFFFB_0000);
    send_word(mk_word(32'h0000_0000, 32'h0001_0000, 32'h0000_0000));
    send_word(mk_word(32'h4000_0000, 32'hFFFF_0000, 32'h0002_0000));
    send_word(mk_word(32'h8000_0000, 32'h0000_0000, 32'hFFFE_0000));
    send_word(mk_word(32'hC000_0000, 32'h0000_8000, 32'h0000_0001));
    send_word(mk_word(32'h3FFF_FFFF, 32'h0003_0000, 32'hFFFF_FFFF));
    send_word(mk_word(32'h7FFF_FFFF, 32'h0000_0001, 32'h0001_0000));
    send_word(mk_word(32'hBFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000));
    send_word(mk_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(mk_word(32'h2000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(mk_word(32'h1234_5678, 32'h0001_921F, 32'hFFF3_0000));
    send_word(mk_word(32'h0000_0001, 32'h0010_0000, 32'h0010_0000));
    send_word(mk_word(32'hE000_0000, 32'hFFF0_0000, 32'hFFF0_0000));
    wait_results_done();
  endtask

  task automatic test_saturation();
    // largest centre and axis push position past range; huge rate makes w*w overflow
    set_ellipse(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(mk_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_word(mk_word(32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(mk_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_word(mk_word(32'hC000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    // registers change only with the pipeline empty
    wait_results_done();
    set_ellipse(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(mk_word(32'h6000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(mk_word(32'hA000_0000, 32'h0100_0000, 32'h0000_0000));
    send_word(mk_word(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000));
    send_word(mk_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    wait_results_done();
  endtask

  task automatic test_backpressure();
    set_ellipse(32'h0002_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h0004_0000);
    tx_gaps_on = 1'b0;
    rx_hold_left = 400;
    // keep offering words while the output is held; the block must stall its input
    repeat (60) send_word(rand_word());
    // sender pauses until everything is back, then streams again
    wait_results_done();
    tx_gaps_on = 1'b1;
    repeat (20) send_word(rand_word());
    wait_results_done();
  endtask

  task automatic test_random_items();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        set_ellipse(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      else if (p == 1)
        set_ellipse(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      else
        set_ellipse(rand_reg_value(), rand_reg_value(), rand_reg_value(),
                    rand_reg_value());
      tx_gaps_on = (p % 4) != 3;
      rx_stalls_on = (p % 3) != 2;
      repeat (WORDS_PER_PHASE) send_word(rand_word());
      wait_results_done();
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cfg_shadow  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed_extremes();
    test_saturation();
    test_backpressure();
    test_random_items();

    wait_results_done();
    if (pending_setpoints.size() != 0)
      report_mismatch("words never returned", pending_setpoints.size(), 32'd0);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
design/ets_pkg.sv
design/ets_front.sv
design/ets_queue.sv
design/ets_cordic.sv
design/ets_back.sv
design/ellipse_trajectory_setpoint.sv
tb/ellipse_trajectory_setpoint_tb.sv
